/* design/rledme_pkg.sv */
// Shared types and character constants for the run-length encoder.
package rledme_pkg;

  // Result group: at most 9 bytes caused by one input word
  localparam int GRP_MAX   = 9;
  localparam int GRP_IDX_W = $clog2(GRP_MAX + 1);
  localparam int DIG_N     = 4;
  localparam int DIG_IDX_W = $clog2(DIG_N);

  typedef logic [7:0]           byte_t;
  typedef logic [3:0]           digit_t;
  typedef logic [GRP_IDX_W-1:0] grp_cnt_t;

  // Group handed from the run stage to the output buffer
  typedef struct packed {
    logic                      vld;
    grp_cnt_t                  cnt;
    logic [GRP_MAX-1:0][7:0]   bytes;
  } grp_t;

  // Output characters
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CH_AT     = 8'h40;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_ONE    = 8'h31;

  localparam digit_t DIGIT_NINE = 4'd9;

endpackage

/* design/rledme_run_stage.sv */
// Input register, decimal run counter and result group builder.
module rledme_run_stage
  import rledme_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_data_byte,
  input  logic  in_line_end,
  input  logic  grp_free,
  output grp_t  grp
);

  logic   vld_r;
  byte_t  byte_r;
  logic   eol_r;

  byte_t  run_byte_r, run_byte_nxt;
  logic   run_open_r, run_open_nxt;
  digit_t dig_r   [DIG_N];
  digit_t dig_nxt [DIG_N];
  digit_t dig_inc [DIG_N];

  logic     at_cap;
  logic     extend;
  logic     advance;
  logic [2:0] num_dig;
  byte_t    marker;
  grp_cnt_t flush_len;
  grp_cnt_t grp_cnt;
  logic [GRP_MAX-1:0][7:0] grp_bytes;

  // Size the count form from the leading nonzero digit
  always_comb begin
    at_cap = 1'b1;
    for (int j = 0; j < DIG_N; j++) begin
      if (dig_r[j] != DIGIT_NINE) at_cap = 1'b0;
    end
    if (dig_r[3] != '0) begin
      num_dig = 3'd4;
      marker  = CH_DOLLAR;
    end else if (dig_r[2] != '0) begin
      num_dig = 3'd3;
      marker  = CH_AT;
    end else if (dig_r[1] != '0 || dig_r[0] == DIGIT_NINE) begin
      num_dig = 3'd2;
      marker  = CH_HASH;
    end else begin
      num_dig = 3'd1;
      marker  = CH_STAR;
    end
  end

  // Decide group length for the held word
  always_comb begin
    extend    = !eol_r && run_open_r && (byte_r == run_byte_r) && !at_cap;
    flush_len = run_open_r ? (grp_cnt_t'(num_dig) + grp_cnt_t'(2)) : '0;
    if (eol_r) begin
      grp_cnt = flush_len + grp_cnt_t'(3);
    end else if (extend) begin
      grp_cnt = '0;
    end else begin
      grp_cnt = flush_len;
    end
  end

  // Lay out marker, digits, run byte and the line-end tail
  always_comb begin
    grp_cnt_t pos;
    grp_cnt_t rel;
    grp_cnt_t dsel;
    for (int i = 0; i < GRP_MAX; i++) begin
      pos  = grp_cnt_t'(i);
      rel  = pos - flush_len;
      dsel = grp_cnt_t'(num_dig) - pos;
      if (pos < flush_len) begin
        if (pos == '0) begin
          grp_bytes[i] = marker;
        end else if (pos <= grp_cnt_t'(num_dig)) begin
          grp_bytes[i] = CH_ZERO | {4'b0000, dig_r[dsel[DIG_IDX_W-1:0]]};
        end else begin
          grp_bytes[i] = run_byte_r;
        end
      end else if (rel == '0) begin
        grp_bytes[i] = CH_STAR;
      end else if (rel == grp_cnt_t'(1)) begin
        grp_bytes[i] = CH_ONE;
      end else begin
        grp_bytes[i] = CH_LF;
      end
    end
  end

  // Decimal increment of the run count
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = 0; j < DIG_N; j++) begin
      if (carry && dig_r[j] == DIGIT_NINE) begin
        dig_inc[j] = '0;
      end else if (carry) begin
        dig_inc[j] = dig_r[j] + digit_t'(1);
        carry      = 1'b0;
      end else begin
        dig_inc[j] = dig_r[j];
      end
    end
  end

  // Next run state
  always_comb begin
    run_byte_nxt = run_byte_r;
    run_open_nxt = run_open_r;
    dig_nxt      = dig_r;
    if (eol_r) begin
      run_open_nxt = 1'b0;
      for (int j = 0; j < DIG_N; j++) dig_nxt[j] = '0;
    end else if (extend) begin
      dig_nxt = dig_inc;
    end else begin
      run_byte_nxt = byte_r;
      run_open_nxt = 1'b1;
      for (int j = 0; j < DIG_N; j++) dig_nxt[j] = '0;
      dig_nxt[0] = digit_t'(1);
    end
  end

  // Advance when no bytes come out or the buffer takes the group
  assign advance  = vld_r && (grp_cnt == '0 || grp_free);
  assign in_stall = vld_r && !advance;

  assign grp.vld   = vld_r;
  assign grp.cnt   = grp_cnt;
  assign grp.bytes = grp_bytes;

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      eol_r  <= in_line_end;
    end
  end

  // Run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r <= '0;
      run_open_r <= 1'b0;
      for (int j = 0; j < DIG_N; j++) dig_r[j] <= '0;
    end else if (advance) begin
      run_byte_r <= run_byte_nxt;
      run_open_r <= run_open_nxt;
      dig_r      <= dig_nxt;
    end
  end

endmodule

/* design/rledme_out_buffer.sv */
// Result buffer that holds one group and drains it a word per cycle unless stalled.
module rledme_out_buffer
  import rledme_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  grp_t  grp,
  output logic  grp_free,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last
);

  logic     busy_r;
  grp_cnt_t idx_r;
  grp_cnt_t cnt_r;
  byte_t    buf_r [GRP_MAX];

  logic pop;
  logic load;

  // Drain control
  assign out_last  = (idx_r == cnt_r - grp_cnt_t'(1));
  assign pop       = busy_r && !out_stall;
  assign grp_free  = !busy_r || (pop && out_last);
  assign load      = grp.vld && grp.cnt != '0 && grp_free;
  assign out_valid = busy_r;
  assign out_byte  = buf_r[idx_r];

  // Advance read index, free on the final word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (pop) begin
      if (out_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + grp_cnt_t'(1);
      end
    end
  end

  // Capture group payload
  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r <= grp.cnt;
      for (int i = 0; i < GRP_MAX; i++) buf_r[i] <= grp.bytes[i];
    end
  end

endmodule

/* design/rle_decimal_marker_encoder_core.sv */
// Top level of the run-length encoder with decimal count markers.
//
// Input channel (in_valid / in_stall): one word per text byte, or a line
// end with in_line_end set. Output channel (out_valid / out_stall): one
// encoded byte per word, out_last on the final byte caused by an input.
// A word is taken when valid is high and stall is low.
// The first encoded byte of a word passes through the input register and
// then the result buffer before it is presented; while the buffer is busy
// with an earlier group, the word waits in the input register.
// Throughput: a word that only extends a run is taken without waiting for the
// buffer. A word that closes a run or ends a line produces 3 to 9 bytes,
// and the single result buffer drains one byte per cycle while out_stall is
// low, so the next such word waits until the last byte of the previous group
// is taken. Words that produce nothing keep flowing while the buffer drains.
// A receiver stall holds the current byte; once the buffer is full the
// held input word stalls the input side.
// Reset (rst_n low, synchronous) closes any open run and empties both
// the input register and the result buffer.
module rle_decimal_marker_encoder_core
  import rledme_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_data_byte,
  input  logic  in_line_end,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last
);

  grp_t grp;
  logic grp_free;

  // Run tracking and group building
  rledme_run_stage u_run_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_line_end  (in_line_end),
    .grp_free     (grp_free),
    .grp          (grp)
  );

  // Result buffer and drain
  rledme_out_buffer u_out_buffer (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .grp_free  (grp_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef NO_ASSERTIONS
  // A blocked group holds its contents until the buffer takes it
  a_grp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (grp.vld && grp.cnt != '0 && !grp_free)
      |=> (grp.vld && $stable(grp.cnt) && $stable(grp.bytes)))
    else $error("blocked result group changed");

  // Input stalls only behind a group waiting for the buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (grp.vld && grp.cnt != '0 && !grp_free))
    else $error("input stalled without a pending group");

  // Buffer frees while busy only as its final word is taken
  a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_free && out_valid) |-> (out_last && !out_stall))
    else $error("result buffer freed early");

  // Groups never exceed the buffer depth
  a_grp_size: assert property (@(posedge clk) disable iff (!rst_n)
    grp.vld |-> (grp.cnt <= grp_cnt_t'(GRP_MAX)))
    else $error("result group too long");
`endif

endmodule
